// ===== rtl/lrfs_pkg.sv =====
// Shared types, constants and helpers for the log record field splitter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package lrfs_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int MAX_FIELDS  = 63;
	localparam int QUEUE_DEPTH = 4;

	localparam int IDX_W  = $clog2(STACK_DEPTH);
	localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
	localparam int FLD_W  = $clog2(MAX_FIELDS + 1);
	localparam int CFG_W  = 6;
	localparam int CNT_W  = ((FLD_W > CFG_W) ? FLD_W : CFG_W) + 1;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam int CHAR_W   = 8;
	localparam int INDEX_W  = 6;
	localparam int ERR_W    = 3;
	localparam int TDATA_W  = 24;
	localparam int TIN_W    = 8;
	localparam int TUSER_W  = 2;
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;

	localparam logic [APB_AW-1:0] ADDR_FIELD_COUNT = 3'h0;
	localparam logic [CFG_W-1:0]  FIELD_COUNT_RST  = 6'd9;

	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;
	localparam logic [CHAR_W-1:0] CH_LBR   = 8'h5B;
	localparam logic [CHAR_W-1:0] CH_RBR   = 8'h5D;

	typedef enum logic [2:0] {
		CLS_OTHER,
		CLS_SPACE,
		CLS_QUOTE,
		CLS_LBR,
		CLS_RBR
	} cls_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_NONE,
		ERR_UNDERFLOW,
		ERR_OVERFLOW,
		ERR_QUOTE_START,
		ERR_TOO_MANY,
		ERR_COUNT
	} err_t;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		cls_t              cls;
		logic              last;
	} item_t;

	function automatic err_t raise_err(err_t cur, err_t code);
		return (cur == ERR_NONE) ? code : cur;
	endfunction

endpackage

// ===== rtl/lrfs_front.sv =====
// Front end: accepts input items and classifies each character.
// Depends on lrfs_pkg; feeds lrfs_queue.
`timescale 1ns / 1ps

module lrfs_front (
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [lrfs_pkg::TIN_W-1:0] s_tdata,   // [7:0] char_in
	input  logic                       s_tlast,   // record_last
	input  logic                       q_full,
	output logic                       q_push,
	output lrfs_pkg::item_t            q_item
);
	import lrfs_pkg::*;

	cls_t cls;

	always_comb begin
		case (s_tdata[CHAR_W-1:0])
			CH_SPACE: cls = CLS_SPACE;
			CH_QUOTE: cls = CLS_QUOTE;
			CH_LBR:   cls = CLS_LBR;
			CH_RBR:   cls = CLS_RBR;
			default:  cls = CLS_OTHER;
		endcase
	end

	assign s_tready    = !q_full;
	assign q_push      = s_tvalid && !q_full;
	assign q_item.ch   = s_tdata[CHAR_W-1:0];
	assign q_item.cls  = cls;
	assign q_item.last = s_tlast;

endmodule

// ===== rtl/lrfs_queue.sv =====
// Short item queue between the classifier and the parser.
// Depends on lrfs_pkg.
`timescale 1ns / 1ps

module lrfs_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  lrfs_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            valid,
	output lrfs_pkg::item_t pop_item
);
	import lrfs_pkg::*;

	item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full     = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign valid    = (cnt_q != '0);
	assign pop_item = mem_q[rd_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop)
				rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("queue count missed a push");

endmodule

// ===== rtl/lrfs_back.sv =====
// Back end: nesting stack, field counter, error latch and output register.
// Depends on lrfs_pkg; drains lrfs_queue.
`timescale 1ns / 1ps

module lrfs_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	input  lrfs_pkg::item_t              q_item,
	output logic                         q_pop,
	input  logic [lrfs_pkg::CFG_W-1:0]   field_count,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [lrfs_pkg::TDATA_W-1:0] m_tdata,  // [7:0] char_out, [13:8] field_index,
	                                               // [16:14] error_code, rest zero
	output logic [lrfs_pkg::TUSER_W-1:0] m_tuser,  // [0] in_field, [1] field_done
	output logic                         m_tlast   // record_done
);
	import lrfs_pkg::*;

	logic              stack_mem [STACK_DEPTH];
	logic [LVL_W-1:0]  lvl_q;
	logic [FLD_W-1:0]  fld_q;
	logic              prev_space_q;
	logic              pend_q;
	logic              start_q;
	err_t              err_q;

	logic              out_valid_q;
	logic [CHAR_W-1:0] out_char_q;
	logic [INDEX_W-1:0] out_idx_q;
	logic              out_content_q;
	logic              out_done_q;
	logic              out_last_q;
	err_t              out_err_q;

	logic              take;
	logic [IDX_W-1:0]  top_idx;
	logic              top_bit;
	logic [LVL_W-1:0]  lvl_d;
	logic [FLD_W-1:0]  fld_d;
	logic              prev_space_d;
	logic              pend_d;
	logic              start_d;
	err_t              err_d;
	logic              push_en;
	logic              push_bit;
	logic              content;
	logic              done;

	assign take    = q_valid && (!out_valid_q || m_tready);
	assign q_pop   = take;
	assign top_idx = IDX_W'(lvl_q - 1'b1);
	assign top_bit = stack_mem[top_idx];

	always_comb begin
		lvl_d        = lvl_q;
		fld_d        = fld_q;
		prev_space_d = prev_space_q;
		pend_d       = 1'b0;
		start_d      = start_q;
		err_d        = err_q;
		push_en      = 1'b0;
		push_bit     = 1'b0;
		content      = 1'b1;
		done         = 1'b0;

		if (pend_q && q_item.cls == CLS_SPACE) begin
			if (lvl_q == '0)
				err_d = raise_err(err_d, ERR_UNDERFLOW);
			else if (!top_bit)
				lvl_d = lvl_q - 1'b1;
		end

		if (q_item.last) begin
			if (CNT_W'(fld_q) + 1'b1 != CNT_W'(field_count))
				err_d = raise_err(err_d, ERR_COUNT);
			content = 1'b0;
			done    = 1'b1;
		end else begin
			case (q_item.cls)
				CLS_SPACE: begin
					if (lvl_d == '0) begin
						if (CNT_W'(fld_q) >= CNT_W'(field_count))
							err_d = raise_err(err_d, ERR_TOO_MANY);
						if (fld_q < FLD_W'(MAX_FIELDS))
							fld_d = fld_q + 1'b1;
						content = 1'b0;
						done    = 1'b1;
					end
				end
				CLS_QUOTE: begin
					if (start_q)
						err_d = raise_err(err_d, ERR_QUOTE_START);
					else if (prev_space_q)
						push_en = 1'b1;
					else
						pend_d = 1'b1;
				end
				CLS_LBR: begin
					push_en  = 1'b1;
					push_bit = 1'b1;
				end
				CLS_RBR: begin
					if (lvl_q == '0)
						err_d = raise_err(err_d, ERR_UNDERFLOW);
					else if (top_bit)
						lvl_d = lvl_q - 1'b1;
				end
				default: begin
				end
			endcase
			if (push_en) begin
				if (lvl_q >= LVL_W'(STACK_DEPTH)) begin
					err_d   = raise_err(err_d, ERR_OVERFLOW);
					push_en = 1'b0;
				end else begin
					lvl_d = lvl_q + 1'b1;
				end
			end
			prev_space_d = (q_item.cls == CLS_SPACE);
			start_d      = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && push_en)
			stack_mem[lvl_q[IDX_W-1:0]] <= push_bit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q        <= '0;
			fld_q        <= '0;
			prev_space_q <= 1'b0;
			pend_q       <= 1'b0;
			start_q      <= 1'b1;
			err_q        <= ERR_NONE;
			out_valid_q  <= 1'b0;
		end else begin
			if (take) begin
				if (q_item.last) begin
					lvl_q        <= '0;
					fld_q        <= '0;
					prev_space_q <= 1'b0;
					pend_q       <= 1'b0;
					start_q      <= 1'b1;
					err_q        <= ERR_NONE;
				end else begin
					lvl_q        <= lvl_d;
					fld_q        <= fld_d;
					prev_space_q <= prev_space_d;
					pend_q       <= pend_d;
					start_q      <= start_d;
					err_q        <= err_d;
				end
			end
			if (take)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_char_q    <= q_item.ch;
			out_idx_q     <= INDEX_W'(fld_q);
			out_content_q <= content;
			out_done_q    <= done;
			out_last_q    <= q_item.last;
			out_err_q     <= err_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(TDATA_W - CHAR_W - INDEX_W - ERR_W)'(0), out_err_q, out_idx_q, out_char_q};
	assign m_tuser  = {out_done_q, out_content_q};
	assign m_tlast  = out_last_q;

	a_lvl_bound: assert property (@(posedge clk) disable iff (!arst_n)
		lvl_q <= LVL_W'(STACK_DEPTH))
		else $error("stack level beyond depth");

	a_rec_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(take && q_item.last) |=> (lvl_q == '0 && fld_q == '0 && start_q && err_q == ERR_NONE))
		else $error("record state not cleared after final item");

	a_err_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !q_item.last && err_q != ERR_NONE) |=> (err_q == $past(err_q)))
		else $error("latched error changed within record");

	a_out_err: assert property (@(posedge clk) disable iff (!arst_n)
		(take && err_q != ERR_NONE) |=> (out_err_q == $past(err_q)))
		else $error("reported error differs from latched error");

endmodule

// ===== rtl/log_record_field_splitter_top.sv =====
// Each accepted item passes through the queue to the parser, which updates stack top, level
// and counters together and registers its result. One item per cycle unless m_tready stalls.
// A four-entry queue parts the classifier from the parser; the output register holds a result
// while the next item is taken. Reset (arst_n, asynchronous, active low) empties the queue,
// clears record state and sets field_count to 9; the nesting stack contents are left as they are.
`timescale 1ns / 1ps

module log_record_field_splitter_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [lrfs_pkg::TIN_W-1:0]   s_tdata,   // [7:0] char_in
	input  logic                         s_tlast,   // record_last
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [lrfs_pkg::TDATA_W-1:0] m_tdata,   // [7:0] char_out, [13:8] field_index,
	                                                // [16:14] error_code, rest zero
	output logic [lrfs_pkg::TUSER_W-1:0] m_tuser,   // [0] in_field, [1] field_done
	output logic                         m_tlast,   // record_done
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [lrfs_pkg::APB_AW-1:0]  paddr,
	input  logic [lrfs_pkg::APB_DW-1:0]  pwdata,
	output logic [lrfs_pkg::APB_DW-1:0]  prdata,
	output logic                         pready
);
	import lrfs_pkg::*;

	logic             fc_wr_en;
	logic [CFG_W-1:0] fc_q;
	logic             q_full;
	logic             q_push;
	item_t            push_item;
	logic             q_valid;
	logic             q_pop;
	item_t            pop_item;

	assign pready   = 1'b1;
	assign fc_wr_en = psel && penable && pwrite && (paddr == ADDR_FIELD_COUNT);
	assign prdata   = (paddr == ADDR_FIELD_COUNT) ? APB_DW'(fc_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fc_q <= FIELD_COUNT_RST;
		else if (fc_wr_en)
			fc_q <= pwdata[CFG_W-1:0];
	end

	lrfs_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (push_item)
	);

	lrfs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.pop_item  (pop_item)
	);

	lrfs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_item      (pop_item),
		.q_pop       (q_pop),
		.field_count (fc_q),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast)
	);

endmodule
